### hw/rtl/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the blob proximity search block.
// ---------------------------------------------------------------------------
package bps_pkg;

  localparam int COORD_W = 20;
  localparam int LABEL_W = 5;
  localparam int DSQ_W   = 42;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // One stored point on its way down the distance chain.
  typedef struct packed {
    logic                      vld;
    logic [LABEL_W-1:0]        label;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [DSQ_W-1:0]          psum;
  } pt_t;

endpackage
`default_nettype wire

### hw/rtl/bps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bps_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/bps_axis_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bps_axis_cell
// One cell of the distance chain: squares one axis difference and adds it
// to the partial sum handed on by the previous cell.
// ---------------------------------------------------------------------------
module bps_axis_cell #(
  parameter int AXIS = 0
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [bps_pkg::COORD_W-1:0]  q,
  input  wire bps_pkg::pt_t                        d_i,
  output bps_pkg::pt_t                             d_o
);

  logic signed [bps_pkg::COORD_W-1:0] s;
  logic signed [bps_pkg::COORD_W:0]   diff;
  logic [bps_pkg::COORD_W:0]          mag;
  logic [bps_pkg::DSQ_W-1:0]          sq;
  bps_pkg::pt_t                       d_r, d_nxt;

  always_comb begin
    case (AXIS)
      0:       s = d_i.x;
      1:       s = d_i.y;
      default: s = d_i.z;
    endcase
    diff  = (bps_pkg::COORD_W+1)'(q) - (bps_pkg::COORD_W+1)'(s);
    mag   = diff[bps_pkg::COORD_W] ? (bps_pkg::COORD_W+1)'(-diff)
                                   : (bps_pkg::COORD_W+1)'(diff);
    sq    = mag * mag;
    d_nxt = d_i;
    d_nxt.psum = d_i.psum + sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_i.vld;
    end
    d_r.label <= d_nxt.label;
    d_r.x     <= d_nxt.x;
    d_r.y     <= d_nxt.y;
    d_r.z     <= d_nxt.z;
    d_r.psum  <= d_nxt.psum;
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

### hw/rtl/blob_proximity_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Load, clear: handled in the idle state. Query: one stored point read per cycle
// from the point RAM, then RAM read and a three-cell chain. Report: one mark bit
// scanned per cycle unless a result is held back by an output stall.
// One transaction is worked at a time.
// Reset (synchronous, active low) clears count, marks, dropped flag, cutoff;
// the point RAM is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// blob_proximity_search
// Fixed-radius near-neighbor search of labeled blob points against atoms.
// ---------------------------------------------------------------------------
module blob_proximity_search #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_BLOBS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [41:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic signed [19:0] in_coord_x,
  input  wire logic signed [19:0] in_coord_y,
  input  wire logic signed [19:0] in_coord_z,
  input  wire logic [4:0]  in_blob_label,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic [4:0]       out_blob_index,
  output logic             out_last,
  output logic             out_overflow
);

  // labels are 5 bits, so at most 32 marks can ever be set
  localparam int NM = (MAX_BLOBS < 32) ? MAX_BLOBS : 32;
  localparam int IW = (NM > 1) ? $clog2(NM) : 1;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = bps_pkg::LABEL_W + 3 * bps_pkg::COORD_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_QUERY  = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [NM-1:0] marks_r, marks_nxt;
  logic        dropped_r, dropped_nxt;
  logic [41:0] cutoff_r;
  logic        rd_vld_r, rd_issue;
  logic signed [19:0] qx_r, qy_r, qz_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r, out_found_nxt;
  logic [4:0]  out_index_r, out_index_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_ovf_r, out_ovf_nxt;

  logic        accept, emit_ok, ram_we, is_last, chain_busy;
  logic [RW-1:0] rdata;
  logic [NM-1:0] higher;
  bps_pkg::pt_t  c_in, c0, c1, c2;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign emit_ok  = !out_valid_r || !out_stall;
  assign ram_we   = accept && (in_action == bps_pkg::ACT_LOAD) &&
                    (count_r < CW'(MAX_POINTS));
  assign rd_issue = (state_r == ST_QUERY) && (idx_r < count_r);
  assign higher   = marks_r >> scan_r;
  assign is_last  = ((higher >> 1) == '0);
  assign chain_busy = rd_vld_r || c0.vld || c1.vld || c2.vld;

  bps_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_blob_label, in_coord_z, in_coord_y, in_coord_x}),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // point enters the chain with a zero partial sum
  always_comb begin
    c_in.vld   = rd_vld_r;
    c_in.x     = rdata[19:0];
    c_in.y     = rdata[39:20];
    c_in.z     = rdata[59:40];
    c_in.label = rdata[64:60];
    c_in.psum  = '0;
  end

  bps_axis_cell #(.AXIS(0)) u_cell_x (.clk(clk), .rst_n(rst_n), .q(qx_r), .d_i(c_in), .d_o(c0));
  bps_axis_cell #(.AXIS(1)) u_cell_y (.clk(clk), .rst_n(rst_n), .q(qy_r), .d_i(c0), .d_o(c1));
  bps_axis_cell #(.AXIS(2)) u_cell_z (.clk(clk), .rst_n(rst_n), .q(qz_r), .d_i(c1), .d_o(c2));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    scan_nxt      = scan_r;
    marks_nxt     = marks_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // chain output: mark the blob of an in-range point
    if (c2.vld && (c2.psum <= cutoff_r) && (32'(c2.label) < NM)) begin
      marks_nxt[c2.label[IW-1:0]] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            bps_pkg::ACT_LOAD: begin
              if (count_r < CW'(MAX_POINTS)) begin
                count_nxt = count_r + CW'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            bps_pkg::ACT_QUERY: begin
              idx_nxt   = '0;
              state_nxt = ST_QUERY;
            end
            bps_pkg::ACT_REPORT: begin
              scan_nxt  = '0;
              state_nxt = ST_REPORT;
            end
            default: begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_QUERY: begin
        if (rd_issue) begin
          idx_nxt = idx_r + CW'(1);
        end else if (!chain_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (marks_r == '0) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_index_nxt = '0;
            out_last_nxt  = 1'b1;
            out_ovf_nxt   = dropped_r;
            state_nxt     = ST_IDLE;
          end
        end else if (marks_r[scan_r]) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b1;
            out_index_nxt = 5'(scan_r);
            out_last_nxt  = is_last;
            out_ovf_nxt   = dropped_r;
            scan_nxt      = scan_r + IW'(1);
            if (is_last) begin
              marks_nxt = '0;
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          scan_nxt = scan_r + IW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      scan_r      <= '0;
      marks_r     <= '0;
      dropped_r   <= 1'b0;
      cutoff_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      scan_r      <= scan_nxt;
      marks_r     <= marks_nxt;
      dropped_r   <= dropped_nxt;
      rd_vld_r    <= rd_issue;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
    end
    if (accept && (in_action == bps_pkg::ACT_QUERY)) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
      qz_r <= in_coord_z;
    end
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_blob_index = out_index_r;
  assign out_last       = out_last_r;
  assign out_overflow   = out_ovf_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_read_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == ST_QUERY)
    else $error("store read outside a query");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_last_r)
    else $error("empty report result not flagged last");

  a_marks_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPORT) && (state_nxt == ST_IDLE) |=> marks_r == '0)
    else $error("marks not cleared after report");

endmodule
`default_nettype wire

### bench/proximity_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// proximity_checker
// Watches both channels of blob_proximity_search. It keeps its own copy of the
// point store, the near marks and the cutoff, predicts each report and
// compares it field by field.
// ---------------------------------------------------------------------------
module proximity_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [bps_pkg::DSQ_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic [1:0]                in_action,
  input  wire logic signed [19:0]        in_coord_x,
  input  wire logic signed [19:0]        in_coord_y,
  input  wire logic signed [19:0]        in_coord_z,
  input  wire logic [4:0]                in_blob_label,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic                      out_found,
  input  wire logic [4:0]                out_blob_index,
  input  wire logic                      out_last,
  input  wire logic                      out_overflow,
  output int                             fail_count,
  output int                             reports_pending,
  output int                             results_checked
);

  localparam int STORE_DEPTH = 1024;

  typedef struct {
    logic       found;
    logic [4:0] blob_index;
    logic       last;
    logic       overflow;
  } blob_hit_t;

  logic signed [19:0]        pt_x [STORE_DEPTH];
  logic signed [19:0]        pt_y [STORE_DEPTH];
  logic signed [19:0]        pt_z [STORE_DEPTH];
  logic [4:0]                pt_label [STORE_DEPTH];
  int                        num_points;
  logic [31:0]               mark_mask;
  logic                      loads_dropped;
  logic [bps_pkg::DSQ_W-1:0] cutoff_sq;
  blob_hit_t                 expected_hits [$];

  function automatic longint unsigned axis_sq(logic signed [19:0] a, logic signed [19:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  task automatic apply_transaction();
    longint unsigned d2;
    blob_hit_t hit;
    int n;
    case (in_action)
      bps_pkg::ACT_LOAD: begin
        if (num_points < STORE_DEPTH) begin
          pt_x[num_points] = in_coord_x;
          pt_y[num_points] = in_coord_y;
          pt_z[num_points] = in_coord_z;
          pt_label[num_points] = in_blob_label;
          num_points++;
        end else begin
          loads_dropped = 1'b1;
        end
      end
      bps_pkg::ACT_QUERY: begin
        for (int i = 0; i < num_points; i++) begin
          d2 = axis_sq(in_coord_x, pt_x[i]) + axis_sq(in_coord_y, pt_y[i]) +
               axis_sq(in_coord_z, pt_z[i]);
          if (d2 <= cutoff_sq) mark_mask[pt_label[i]] = 1'b1;
        end
      end
      bps_pkg::ACT_REPORT: begin
        n = 0;
        for (int b = 0; b < 32; b++) begin
          if (mark_mask[b]) begin
            hit.found = 1'b1;
            hit.blob_index = 5'(b);
            hit.last = 1'b0;
            hit.overflow = loads_dropped;
            expected_hits.insert(expected_hits.size(), hit);
            n++;
          end
        end
        if (n == 0) begin
          hit.found = 1'b0;
          hit.blob_index = '0;
          hit.last = 1'b1;
          hit.overflow = loads_dropped;
          expected_hits.insert(expected_hits.size(), hit);
        end else begin
          expected_hits[expected_hits.size() - 1].last = 1'b1;
        end
        mark_mask = '0;
      end
      bps_pkg::ACT_CLEAR: begin
        num_points = 0;
        loads_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic compare_result();
    blob_hit_t want;
    if (expected_hits.size() == 0) begin
      $error("unexpected result: found=%0d blob_index=%0d", out_found, out_blob_index);
      fail_count++;
      return;
    end
    want = expected_hits.pop_front();
    results_checked++;
    if (out_found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, out_found);
      fail_count++;
    end
    if (out_blob_index !== want.blob_index) begin
      $error("blob_index: expected %0d, got %0d", want.blob_index, out_blob_index);
      fail_count++;
    end
    if (out_last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, out_last);
      fail_count++;
    end
    if (out_overflow !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    results_checked = 0;
    reports_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      num_points = 0;
      mark_mask = '0;
      loads_dropped = 1'b0;
      cutoff_sq = '0;
      expected_hits.delete();
    end else begin
      if (cfg_we) cutoff_sq = cfg_wdata;
      if (in_valid && !in_stall) apply_transaction();
      if (out_valid && !out_stall) compare_result();
    end
    reports_pending = expected_hits.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives blob_proximity_search with directed and random point loads, atom
// queries, reports and store clears under several cutoffs and stall mixes.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 3000000;
  // Worst quiet time: a query over a full store, during which no result comes out.
  localparam int DRAIN_CYCLES = 1100;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [41:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic signed [19:0] in_coord_x;
  logic signed [19:0] in_coord_y;
  logic signed [19:0] in_coord_z;
  logic [4:0]         in_blob_label;
  logic               out_valid;
  logic               out_stall;
  logic               out_found;
  logic [4:0]         out_blob_index;
  logic               out_last;
  logic               out_overflow;

  int fail_count;
  int reports_pending;
  int results_checked;
  int sender_idle_pct;
  int receiver_idle_pct;
  int transactions_sent;
  int cycle_count;
  bit long_hold_req;
  logic signed [19:0] cx, cy, cz;  // center of the current point cluster

  blob_proximity_search u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_blob_label(in_blob_label),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_blob_index(out_blob_index), .out_last(out_last), .out_overflow(out_overflow)
  );

  proximity_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_blob_label(in_blob_label),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_blob_index(out_blob_index), .out_last(out_last), .out_overflow(out_overflow),
    .fail_count(fail_count), .reports_pending(reports_pending),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: random stall, or one long hold-off when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        out_stall <= rst_n && ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // One transaction on the input channel; valid stays high afterwards so
  // back-to-back transactions never lower and raise it in one step.
  task automatic send(logic [1:0] act, logic signed [19:0] x, logic signed [19:0] y,
                      logic signed [19:0] z, logic [4:0] label);
    int gap;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_blob_label <= label;
    do @(posedge clk); while (!(in_valid && !in_stall));
    transactions_sent++;
  endtask

  // Drop valid, let all reports come back, then let a long query finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [41:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [19:0] near_coord(logic signed [19:0] c);
    return c + 20'(int'($urandom_range(2048)) - 1024);
  endfunction

  // Mostly clustered points and atoms so that marks actually get set.
  task automatic random_transaction();
    int pick;
    logic signed [19:0] x, y, z;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      x = 20'($urandom);
      y = 20'($urandom);
      z = 20'($urandom);
    end else begin
      x = near_coord(cx);
      y = near_coord(cy);
      z = near_coord(cz);
    end
    if (pick < 40)      send(bps_pkg::ACT_LOAD, x, y, z, 5'($urandom));
    else if (pick < 75) send(bps_pkg::ACT_QUERY, x, y, z, 5'($urandom));
    else if (pick < 92) send(bps_pkg::ACT_REPORT, x, y, z, 5'($urandom));
    else                send(bps_pkg::ACT_CLEAR, x, y, z, 5'($urandom));
  endtask

  task automatic random_phase(int count);
    cx = 20'($urandom);
    cy = 20'($urandom);
    cz = 20'($urandom);
    for (int i = 0; i < count; i++) random_transaction();
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_action = bps_pkg::ACT_LOAD;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_blob_label = '0;
    long_hold_req = 1'b0;
    transactions_sent = 0;
    sender_idle_pct = 26;
    receiver_idle_pct = 55;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero cutoff means only an exact hit counts.
    write_cutoff('0);
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);  // nothing marked yet
    send(bps_pkg::ACT_LOAD, '0, '0, '0, 5'd0);
    send(bps_pkg::ACT_LOAD, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 5'd31);
    send(bps_pkg::ACT_LOAD, -20'sh80000, -20'sh80000, -20'sh80000, 5'd5);
    send(bps_pkg::ACT_QUERY, '0, '0, '0, 5'd31);
    send(bps_pkg::ACT_QUERY, 20'sh1, '0, '0, '0);  // one LSB away, misses
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);

    // Widest cutoff: even corner to corner is near.
    write_cutoff(42'h3FF_FFFF_FFFF);
    send(bps_pkg::ACT_QUERY, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, '0);
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);
    // Clearing the store keeps the marks already set.
    send(bps_pkg::ACT_QUERY, -20'sh80000, 20'sh7FFFF, '0, '0);
    send(bps_pkg::ACT_CLEAR, '0, '0, '0, '0);
    send(bps_pkg::ACT_QUERY, '0, '0, '0, '0);
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);

    // Back-pressure: park the result side while a report and more input queue.
    write_cutoff(42'd4000000);
    for (int i = 0; i < 8; i++)
      send(bps_pkg::ACT_LOAD, 20'(i * 512), '0, '0, 5'(i * 3));
    send(bps_pkg::ACT_QUERY, '0, '0, '0, '0);
    long_hold_req = 1'b1;
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);
    for (int i = 0; i < 6; i++) send(bps_pkg::ACT_QUERY, 20'(i * 700), '0, '0, '0);
    send(bps_pkg::ACT_REPORT, '0, '0, '0, '0);
    send(bps_pkg::ACT_CLEAR, '0, '0, '0, '0);

    // Random: three idling mixes, each under its own cutoff.
    write_cutoff(42'($urandom_range(1 << 24)));
    random_phase(22);
    sender_idle_pct = 55;
    receiver_idle_pct = 26;
    write_cutoff(42'($urandom_range(1 << 22)));
    random_phase(22);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_cutoff({10'($urandom), 32'($urandom)});
    random_phase(22);

    wait_idle();
    $display("sent %0d transactions, checked %0d report results", transactions_sent,
             results_checked);
    $display("covered exact and full-range cutoffs, store clears and long result stalls");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
